### rtl/core/angle_bias_kalman_filter_core_defines.svh
// Assertion macros used by the checker of the angle and bias filter core.
`ifndef ANGLE_BIAS_KALMAN_FILTER_CORE_DEFINES_SVH
`define ANGLE_BIAS_KALMAN_FILTER_CORE_DEFINES_SVH

// General property, checked on every rising edge outside reset.
`define ABKF_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("abkf assertion failed");

// A signal holds while its transaction is offered but not taken.
`define ABKF_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (vld && !rdy) |=> $stable(sig)) \
		else $error("abkf payload changed while stalled");

`endif

### rtl/core/abkf_pkg.sv
// Package of the angle and bias filter core: widths, constants and helpers.
`timescale 1ns / 1ps
package abkf_pkg;
	localparam int FRAC_BITS = 24;
	localparam int DATA_W    = 32;
	localparam int CFG_W     = 31;
	localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;
	localparam int WIDE_W    = PROD_W + 2;
	localparam int NUM_W     = DATA_W + FRAC_BITS;
	localparam int DEN_W     = DATA_W + 1;
	localparam int MUL_CNT_W = $clog2(DATA_W);
	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd3;

	// Reset values: round(value * 2^FRAC_BITS).
	localparam longint unsigned DT_RST64 =
		((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000;
	localparam longint unsigned QA_RST64 =
		((64'd5 << FRAC_BITS) + 64'd500000) / 64'd1000000;
	localparam longint unsigned QB_RST64 =
		((64'd15 << FRAC_BITS) + 64'd500000) / 64'd1000000;
	localparam longint unsigned R_RST64 =
		((64'd3 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam logic [CFG_W-1:0] TIME_STEP_RST     = CFG_W'(DT_RST64);
	localparam logic [CFG_W-1:0] ANGLE_NOISE_RST   = CFG_W'(QA_RST64);
	localparam logic [CFG_W-1:0] BIAS_NOISE_RST    = CFG_W'(QB_RST64);
	localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = CFG_W'(R_RST64);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	// Sign-extend a data word to the wide sum width.
	function automatic wide_t ext_d(input data_t v);
		return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	// Sign-extend a rounded product to the wide sum width.
	function automatic wide_t ext_p(input prod_t v);
		return {{(WIDE_W-PROD_W){v[PROD_W-1]}}, v};
	endfunction

	// Zero-extend an unsigned register value to the wide sum width.
	function automatic wide_t ext_c(input logic [CFG_W-1:0] v);
		return {{(WIDE_W-CFG_W){1'b0}}, v};
	endfunction

	// Clamp a wide sum to the signed data range.
	function automatic data_t sat32(input wide_t v);
		data_t r;
		if (v[WIDE_W-1:DATA_W-1] == '0 || v[WIDE_W-1:DATA_W-1] == '1) begin
			r = v[DATA_W-1:0];
		end else if (v[WIDE_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction
endpackage

### rtl/core/abkf_if.sv
// Channel interfaces of the angle and bias filter core.
`timescale 1ns / 1ps
interface abkf_smp_if import abkf_pkg::*; ;
	logic  valid;
	logic  ready;
	data_t measured_angle;
	data_t rate_input;
	modport source (output valid, output measured_angle, output rate_input, input ready);
	modport sink (input valid, input measured_angle, input rate_input, output ready);
endinterface

interface abkf_res_if import abkf_pkg::*; ;
	logic  valid;
	logic  ready;
	data_t estimated_angle;
	data_t estimated_bias;
	modport source (output valid, output estimated_angle, output estimated_bias, input ready);
	modport sink (input valid, input estimated_angle, input estimated_bias, output ready);
endinterface

interface abkf_cfg_if import abkf_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/abkf_ser_mul.sv
// Bit-serial signed multiplier with rounding shift by the fraction width.
`timescale 1ns / 1ps
module abkf_ser_mul import abkf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  data_t a,
	input  data_t b,
	output logic  done,
	output prod_t prod
);
	localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(DATA_W - 1);

	logic                 busy_q;
	logic                 fin_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	data_t                a_q;
	logic [DATA_W:0]      hi_q;
	logic [DATA_W-1:0]    lo_q;
	prod_t                prod_q;

	logic [DATA_W+1:0]   a_ext;
	logic [DATA_W+1:0]   addend;
	logic [DATA_W+1:0]   sum;
	logic [2*DATA_W-1:0] full;
	logic [2*DATA_W-1:0] rounded;

	// One multiplier bit per cycle; the sign bit has negative weight.
	always_comb begin
		a_ext = {{2{a_q[DATA_W-1]}}, a_q};
		if (!lo_q[0]) begin
			addend = '0;
		end else if (cnt_q == CNT_LAST) begin
			addend = -a_ext;
		end else begin
			addend = a_ext;
		end
		sum     = {hi_q[DATA_W], hi_q} + addend;
		full    = {hi_q[DATA_W-1:0], lo_q};
		rounded = full + ((2*DATA_W)'(1) << (FRAC_BITS - 1));
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// Partial product shift register and rounded result.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[DATA_W+1:1];
			lo_q <= {sum[0], lo_q[DATA_W-1:1]};
		end
		if (fin_q) begin
			prod_q <= rounded[2*DATA_W-1:FRAC_BITS];
		end
	end

	assign done = done_q;
	assign prod = prod_q;
endmodule

### rtl/core/abkf_ser_div.sv
// Bit-serial restoring divider for the gains, rounded to nearest and clamped.
`timescale 1ns / 1ps
module abkf_ser_div import abkf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  data_t            num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output data_t            quo
);
	localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(NUM_W - 1);

	logic                 busy_q;
	logic                 fin_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [DEN_W-1:0]     d_q;
	logic [DEN_W-1:0]     rem_q;
	logic [NUM_W-1:0]     q_q;
	data_t                quo_q;

	logic [DATA_W-1:0] mag;
	logic [DEN_W:0]    trial;
	logic              fits;
	logic              rnd;
	logic [NUM_W:0]    qr;
	logic              big;
	data_t             res;

	// One quotient bit per cycle, then round and clamp.
	always_comb begin
		mag   = num[DATA_W-1] ? (DATA_W'(0) - num) : num;
		trial = {rem_q, q_q[NUM_W-1]};
		fits  = trial >= {1'b0, d_q};
		rnd   = {rem_q, 1'b0} >= {1'b0, d_q};
		qr    = {1'b0, q_q} + (NUM_W+1)'(rnd);
		big   = |qr[NUM_W:DATA_W-1];
		if (neg_q) begin
			res = big ? {1'b1, {(DATA_W-1){1'b0}}} : (DATA_W'(0) - {1'b0, qr[DATA_W-2:0]});
		end else begin
			res = big ? {1'b0, {(DATA_W-1){1'b1}}} : {1'b0, qr[DATA_W-2:0]};
		end
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DATA_W-1];
			d_q   <= den;
			rem_q <= '0;
			q_q   <= {mag, {FRAC_BITS{1'b0}}};
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, d_q}) : trial[DEN_W-1:0];
			q_q   <= {q_q[NUM_W-2:0], fits};
		end
		if (fin_q) begin
			quo_q <= res;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

### rtl/core/angle_bias_kalman_filter_core.sv
// Two-state angle and gyro bias filter with a shared serial multiplier and divider.
//
// Channels: samp takes one sample (measured_angle, rate_input, signed Q8.24) per
// transaction; result returns one transaction (estimated_angle, estimated_bias)
// per sample. cfg writes time_step, angle_noise, bias_noise and measure_noise
// by index; it is always ready, and must be written only while no sample is in
// flight; the block itself does not enforce this. Each sample runs ten
// multiplies (one bit per cycle over 32 bits) and two gain divisions (one
// quotient bit per cycle over 56 bits) in turn on the serial units. When the
// innovation variance is not positive the divisions are skipped. One sample
// is processed at a time: samp is not ready again until the result of the
// sample has been taken.
// Reset clears the estimates and covariance to zero and loads the default
// registers. While the receiver stalls, result holds its payload and samp
// stays not ready.
`timescale 1ns / 1ps
module angle_bias_kalman_filter_core import abkf_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	abkf_cfg_if.sink    cfg,
	abkf_smp_if.sink    samp,
	abkf_res_if.source  result
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	localparam logic [3:0] STEP_ANG = 4'd0;
	localparam logic [3:0] STEP_T0  = 4'd1;
	localparam logic [3:0] STEP_N01 = 4'd2;
	localparam logic [3:0] STEP_N00 = 4'd3;
	localparam logic [3:0] STEP_K0  = 4'd4;
	localparam logic [3:0] STEP_K1  = 4'd5;
	localparam logic [3:0] STEP_UA  = 4'd6;
	localparam logic [3:0] STEP_UB  = 4'd7;
	localparam logic [3:0] STEP_AA  = 4'd8;
	localparam logic [3:0] STEP_AB  = 4'd9;
	localparam logic [3:0] STEP_BA  = 4'd10;
	localparam logic [3:0] STEP_BB  = 4'd11;

	logic [1:0] state_q;
	logic [3:0] step_q;

	logic [CFG_W-1:0] dt_q;
	logic [CFG_W-1:0] qa_q;
	logic [CFG_W-1:0] qb_q;
	logic [CFG_W-1:0] r_q;

	data_t angle_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	data_t y_q, diff_q, angp_q, e_q, t0_q;
	data_t n00_q, n01_q, n10_q, n11_q, k0_q, k1_q;

	logic             mul_start, mul_done;
	data_t            mul_a, mul_b;
	prod_t            prod;
	logic             div_start, div_done;
	data_t            div_num;
	data_t            quo;
	logic             is_div;
	logic             unit_done;
	logic signed [DATA_W+1:0] s_full;
	logic             s_pos;
	data_t            dt_s;

	// Handshakes and result payload.
	assign cfg.ready              = 1'b1;
	assign samp.ready             = (state_q == ST_IDLE);
	assign result.valid           = (state_q == ST_OUT);
	assign result.estimated_angle = angle_q;
	assign result.estimated_bias  = bias_q;

	// Configuration registers; bit 31 of the write data is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= TIME_STEP_RST;
			qa_q <= ANGLE_NOISE_RST;
			qb_q <= BIAS_NOISE_RST;
			r_q  <= MEASURE_NOISE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TIME_STEP:     dt_q <= cfg.data[CFG_W-1:0];
				REG_ANGLE_NOISE:   qa_q <= cfg.data[CFG_W-1:0];
				REG_BIAS_NOISE:    qb_q <= cfg.data[CFG_W-1:0];
				REG_MEASURE_NOISE: r_q  <= cfg.data[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Innovation variance, held exactly, and operand selection per step.
	always_comb begin
		dt_s    = {1'b0, dt_q};
		s_full  = {{2{n00_q[DATA_W-1]}}, n00_q} + (DATA_W+2)'(r_q);
		s_pos   = !s_full[DATA_W+1] && (s_full != '0);
		is_div  = (step_q == STEP_K0) || (step_q == STEP_K1);
		div_num = (step_q == STEP_K0) ? n00_q : n10_q;
		unit_done = is_div ? div_done : mul_done;
		case (step_q)
			STEP_ANG: begin mul_a = dt_s; mul_b = diff_q; end
			STEP_T0:  begin mul_a = dt_s; mul_b = ba_q;   end
			STEP_N01: begin mul_a = dt_s; mul_b = bb_q;   end
			STEP_N00: begin mul_a = dt_s; mul_b = n01_q;  end
			STEP_UA:  begin mul_a = k0_q; mul_b = e_q;    end
			STEP_UB:  begin mul_a = k1_q; mul_b = e_q;    end
			STEP_AA:  begin mul_a = k0_q; mul_b = n00_q;  end
			STEP_AB:  begin mul_a = k0_q; mul_b = n01_q;  end
			STEP_BA:  begin mul_a = k1_q; mul_b = n00_q;  end
			STEP_BB:  begin mul_a = k1_q; mul_b = n01_q;  end
			default:  begin mul_a = '0;   mul_b = '0;     end
		endcase
		mul_start = (state_q == ST_ISSUE) && !is_div;
		div_start = (state_q == ST_ISSUE) && is_div && s_pos;
	end

	abkf_ser_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	abkf_ser_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (s_full[DEN_W-1:0]),
		.done   (div_done),
		.quo    (quo)
	);

	// Sequencer over the predict and correct steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_ANG;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (samp.valid) begin
						state_q <= ST_ISSUE;
						step_q  <= STEP_ANG;
					end
				end
				ST_ISSUE: begin
					if (step_q == STEP_K0 && !s_pos) begin
						step_q <= STEP_UA;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (unit_done) begin
						if (step_q == STEP_BB) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_ISSUE;
							step_q  <= step_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Filter state and intermediates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			bias_q  <= '0;
			aa_q    <= '0;
			ab_q    <= '0;
			ba_q    <= '0;
			bb_q    <= '0;
		end else if (state_q == ST_WAIT && unit_done) begin
			case (step_q)
				STEP_UA: angle_q <= sat32(ext_d(angp_q) + ext_p(prod));
				STEP_UB: bias_q  <= sat32(ext_d(bias_q) + ext_p(prod));
				STEP_AA: aa_q    <= sat32(ext_d(n00_q) - ext_p(prod));
				STEP_AB: ab_q    <= sat32(ext_d(n01_q) - ext_p(prod));
				STEP_BA: ba_q    <= sat32(ext_d(n10_q) - ext_p(prod));
				STEP_BB: bb_q    <= sat32(ext_d(n11_q) - ext_p(prod));
				default: ;
			endcase
		end
	end

	// Working registers of one sample.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && samp.valid) begin
			y_q    <= samp.measured_angle;
			diff_q <= sat32(ext_d(samp.rate_input) - ext_d(bias_q));
		end
		if (state_q == ST_ISSUE && step_q == STEP_K0 && !s_pos) begin
			k0_q <= '0;
			k1_q <= '0;
		end
		if (state_q == ST_WAIT && unit_done) begin
			case (step_q)
				STEP_ANG: angp_q <= sat32(ext_d(angle_q) + ext_p(prod));
				STEP_T0: begin
					t0_q <= sat32(ext_d(aa_q) - ext_p(prod));
					e_q  <= sat32(ext_d(y_q) - ext_d(angp_q));
				end
				STEP_N01: begin
					n01_q <= sat32(ext_d(ab_q) - ext_p(prod));
					n10_q <= sat32(ext_d(ba_q) - ext_p(prod));
					n11_q <= sat32(ext_d(bb_q) + ext_c(qb_q));
				end
				STEP_N00: n00_q <= sat32(ext_d(t0_q) - ext_p(prod) + ext_c(qa_q));
				STEP_K0:  k0_q  <= quo;
				STEP_K1:  k1_q  <= quo;
				default: ;
			endcase
		end
	end
endmodule

### rtl/core/abkf_checker.sv
// Port-level checker of the angle and bias filter core, bound to the top level.
`timescale 1ns / 1ps
`include "angle_bias_kalman_filter_core_defines.svh"
module abkf_checker import abkf_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input data_t out_angle,
	input data_t out_bias
);
	// A sample is never taken while a result waits.
	`ABKF_ASSERT(a_in_excl_out, clk, arst_n, (in_valid && in_ready) |-> !out_valid)
	// A sample transaction starts work: no result and no new sample next cycle.
	`ABKF_ASSERT(a_in_starts, clk, arst_n, (in_valid && in_ready) |=> (!out_valid && !in_ready))
	// After the result transaction the block is ready for a new sample.
	`ABKF_ASSERT(a_out_frees, clk, arst_n, (out_valid && out_ready) |=> in_ready)
	// A stalled result stays offered with the same payload.
	`ABKF_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> out_valid)
	`ABKF_ASSERT_HOLD(a_angle_hold, clk, arst_n, out_valid, out_ready, out_angle)
	`ABKF_ASSERT_HOLD(a_bias_hold, clk, arst_n, out_valid, out_ready, out_bias)
endmodule

bind angle_bias_kalman_filter_core abkf_checker u_abkf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samp.valid),
	.in_ready  (samp.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_angle (result.estimated_angle),
	.out_bias  (result.estimated_bias)
);

### dv/tb_angle_bias_kalman_filter_core.sv
// Self-checking testbench of the angle and bias filter core.
`timescale 1ns / 1ps
module tb_angle_bias_kalman_filter_core;
	import abkf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	abkf_cfg_if cfg_ch ();
	abkf_smp_if samp_ch ();
	abkf_res_if res_ch ();

	angle_bias_kalman_filter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch.sink),
		.samp(samp_ch.sink),
		.result(res_ch.source)
	);

	always #4 clk = ~clk;

	typedef struct {
		data_t angle;
		data_t bias;
	} estimate_t;

	// Predictor copy of the registers and the filter state.
	longint dt_reg, qa_reg, qb_reg, r_reg;
	longint ang_st, bia_st, p_aa, p_ab, p_ba, p_bb;
	estimate_t estimate_q[$];
	int err_cnt = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// Clamp to the signed 32-bit range.
	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Fixed point product, rounded half up by an arithmetic shift.
	function automatic longint qmul(longint a, longint b);
		longint p;
		p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
		return p >>> FRAC_BITS;
	endfunction

	// Fixed point quotient, rounded half away from zero; den is positive.
	function automatic longint qdiv(longint num, longint den);
		longint unsigned n, q;
		longint r;
		n = (num < 0 ? -num : num);
		n = n << FRAC_BITS;
		q = (2 * n + den) / (2 * den);
		r = q;
		return clamp32(num < 0 ? -r : r);
	endfunction

	// Run one filter step on the predictor state and queue the estimate.
	task automatic filter_step(data_t y, data_t u);
		longint diff, ang_p, t0, n00, n01, n10, n11, e, s, k0, k1;
		estimate_t est;
		diff = clamp32(longint'(u) - bia_st);
		ang_p = clamp32(ang_st + qmul(dt_reg, diff));
		t0 = clamp32(p_aa - qmul(dt_reg, p_ba));
		n01 = clamp32(p_ab - qmul(dt_reg, p_bb));
		n00 = clamp32(t0 - qmul(dt_reg, n01) + qa_reg);
		n10 = clamp32(p_ba - qmul(dt_reg, p_bb));
		n11 = clamp32(p_bb + qb_reg);
		e = clamp32(longint'(y) - ang_p);
		s = n00 + r_reg;
		k0 = 0;
		k1 = 0;
		if (s > 0) begin
			k0 = qdiv(n00, s);
			k1 = qdiv(n10, s);
		end
		ang_st = clamp32(ang_p + qmul(k0, e));
		bia_st = clamp32(bia_st + qmul(k1, e));
		p_aa = clamp32(n00 - qmul(k0, n00));
		p_ab = clamp32(n01 - qmul(k0, n01));
		p_ba = clamp32(n10 - qmul(k1, n00));
		p_bb = clamp32(n11 - qmul(k1, n01));
		est.angle = data_t'(ang_st);
		est.bias = data_t'(bia_st);
		estimate_q.push_back(est);
	endtask

	// Send one sample transaction and predict its estimate.
	task automatic send_sample(data_t y, data_t u);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
			@(negedge clk);
		samp_ch.valid <= 1'b1;
		samp_ch.measured_angle <= y;
		samp_ch.rate_input <= u;
		@(posedge clk);
		while (!samp_ch.ready) @(posedge clk);
		filter_step(y, u);
		@(negedge clk);
		samp_ch.valid <= 1'b0;
	endtask

	// Wait until every estimate has come back and the core is idle.
	task automatic drain();
		while (estimate_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Write one register; only called while the core is idle.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_TIME_STEP: dt_reg = longint'(val[CFG_W-1:0]);
			REG_ANGLE_NOISE: qa_reg = longint'(val[CFG_W-1:0]);
			REG_BIAS_NOISE: qb_reg = longint'(val[CFG_W-1:0]);
			REG_MEASURE_NOISE: r_reg = longint'(val[CFG_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_regs(longint dt, longint qa, longint qb, longint r);
		write_reg(REG_TIME_STEP, DATA_W'(dt));
		write_reg(REG_ANGLE_NOISE, DATA_W'(qa));
		write_reg(REG_BIAS_NOISE, DATA_W'(qb));
		write_reg(REG_MEASURE_NOISE, DATA_W'(r));
	endtask

	function automatic data_t rand_word();
		case ($urandom_range(3, 0))
			0: return data_t'($urandom);
			1: return data_t'($signed($urandom_range(2 ** 26, 0)) - 2 ** 25);
			2: return data_t'($signed($urandom_range(2 ** 18, 0)) - 2 ** 17);
			default: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	// Directed extremes at the reset settings.
	task automatic test_extremes();
		send_sample(32'sd0, 32'sd0);
		send_sample(32'sh7fffffff, 32'sh7fffffff);
		send_sample(32'sh80000000, 32'sh80000000);
		send_sample(32'sh7fffffff, 32'sh80000000);
		send_sample(32'sh80000000, 32'sh7fffffff);
		send_sample(32'sh01000000, 32'shff000000);
		send_sample(32'sh55555555, 32'shaaaaaaaa);
		send_sample(32'shaaaaaaaa, 32'sh55555555);
		drain();
	endtask

	// Extremes of the innovation variance: no noise at all, then huge noise.
	task automatic test_zero_variance();
		set_regs(0, 0, 0, 0);
		send_sample(32'sh01000000, 32'sh00800000);
		send_sample(32'sh80000000, 32'sh7fffffff);
		drain();
		set_regs(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
		repeat (6) send_sample(rand_word(), rand_word());
		drain();
		// Bits above the register width are dropped; index values cover all registers.
		set_regs(32'hffffffff, 32'h80000054, 32'h800000fc, 32'h8007ae14);
		send_sample(32'sh00100000, 32'sh00010000);
		drain();
	endtask

	// Random samples over a series of register settings.
	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) begin
				drain();
				case ($urandom_range(3, 0))
					0: set_regs(TIME_STEP_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST,
						MEASURE_NOISE_RST);
					1: set_regs($urandom_range(2 ** 25, 0), $urandom_range(2 ** 12, 0),
						$urandom_range(2 ** 12, 0), $urandom_range(2 ** 24, 1));
					2: set_regs($urandom, $urandom, $urandom, $urandom_range(32'h7fffffff, 1));
					default: set_regs($urandom_range(2 ** 22, 0), 0, 0, 1);
				endcase
			end
			send_sample(rand_word(), rand_word());
		end
		drain();
	endtask

	// Result checker and receiver stall.
	always @(posedge clk) begin
		estimate_t exp_est;
		if (res_ch.valid && res_ch.ready) begin
			if (estimate_q.size() == 0) begin
				$error("estimate with no sample pending");
				err_cnt++;
			end else begin
				exp_est = estimate_q.pop_front();
				if (res_ch.estimated_angle !== exp_est.angle) begin
					$error("estimated_angle expected %0d actual %0d", exp_est.angle,
						res_ch.estimated_angle);
					err_cnt++;
				end
				if (res_ch.estimated_bias !== exp_est.bias) begin
					$error("estimated_bias expected %0d actual %0d", exp_est.bias,
						res_ch.estimated_bias);
					err_cnt++;
				end
			end
		end
	end

	always @(negedge clk) begin
		res_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
	end

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		samp_ch.valid = 1'b0;
		samp_ch.measured_angle = '0;
		samp_ch.rate_input = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TIME_STEP;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		dt_reg = TIME_STEP_RST;
		qa_reg = ANGLE_NOISE_RST;
		qb_reg = BIAS_NOISE_RST;
		r_reg = MEASURE_NOISE_RST;
		ang_st = 0; bia_st = 0; p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_zero_variance();
		send_idle_pct = 17;
		recv_idle_pct = 88;
		test_random(230);
		send_idle_pct = 88;
		recv_idle_pct = 17;
		test_random(230);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(240);
		repeat (500) @(negedge clk);
		if (err_cnt == 0 && estimate_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
